>>> src/strict_priority_class_queues_top_macros.svh
// Assertion macros shared by the strict priority class queue RTL.
`ifndef STRICT_PRIORITY_CLASS_QUEUES_TOP_MACROS_SVH
`define STRICT_PRIORITY_CLASS_QUEUES_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SPCQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPCQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define SPCQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPCQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/spcq_pkg.sv
// Package: shared constants, codes and types of the strict priority class queues.
`default_nettype none
package spcq_pkg;
    localparam int TOTAL_SLOTS_DEF = 32;
    localparam int DATA_BITS_DEF   = 32;
    localparam int DEPTH_W         = 8;
    localparam int SIZE_W          = 8;
    localparam int CMD_FIFO_DEPTH  = 2;
    localparam logic [DEPTH_W-1:0] CLASS0_DEPTH_RST = 8'd16;
    localparam logic [DEPTH_W-1:0] CLASS1_DEPTH_RST = 8'd16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic {
        CFG_CLASS0_DEPTH = 1'b0,
        CFG_CLASS1_DEPTH = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic    wr;
        logic    rd;
        t_status status;
        logic    cls;
    } t_cmd_ctl;

    localparam int CMD_CTL_W = $bits(t_cmd_ctl);
endpackage
`default_nettype wire

>>> src/spcq_in_if.sv
// Interface: request channel carrying enqueue and dequeue commands.
`default_nettype none
interface spcq_in_if #(
    parameter int DATA_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic                 queue_class;
    logic [7:0]           packet_size;
    logic [DATA_BITS-1:0] packet_data;

    modport source (output valid, output operation, output queue_class,
                    output packet_size, output packet_data, input ready);
    modport sink   (input valid, input operation, input queue_class,
                    input packet_size, input packet_data, output ready);
endinterface
`default_nettype wire

>>> src/spcq_out_if.sv
// Interface: result channel carrying status and dequeued packets.
`default_nettype none
interface spcq_out_if #(
    parameter int DATA_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic                 out_class;
    logic [7:0]           out_size;
    logic [DATA_BITS-1:0] out_data;

    modport source (output valid, output status, output out_class,
                    output out_size, output out_data, input ready);
    modport sink   (input valid, input status, input out_class,
                    input out_size, input out_data, output ready);
endinterface
`default_nettype wire

>>> src/spcq_front.sv
// Front end: ring bookkeeping, classification and slot address generation.
`default_nettype none
module spcq_front
    import spcq_pkg::*;
#(
    parameter int TOTAL_SLOTS = TOTAL_SLOTS_DEF,
    parameter int DATA_BITS   = DATA_BITS_DEF,
    localparam int AW         = $clog2(TOTAL_SLOTS)
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire  [DEPTH_W-1:0]   i_cfg_data,
    spcq_in_if.sink              i_in,
    input  wire                  i_fifo_full,
    output logic                 o_push,
    output t_cmd_ctl             o_ctl,
    output logic [AW-1:0]        o_addr,
    output logic [SIZE_W-1:0]    o_size,
    output logic [DATA_BITS-1:0] o_data
);
    // Reciprocal of the store size, exact for every sum of base and position.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + TOTAL_SLOTS - 1) / TOTAL_SLOTS;

    logic [DEPTH_W-1:0] r_depth0, r_depth1;
    logic [DEPTH_W-1:0] r_rp [2];
    logic [DEPTH_W-1:0] r_wp [2];
    logic [1:0]         r_wf;
    logic [DEPTH_W-1:0] n_rp [2];
    logic [DEPTH_W-1:0] n_wp [2];
    logic [1:0]         n_wf;

    logic [1:0]         w_empty, w_full;
    logic               w_deq, w_sel, w_acc;
    logic [DEPTH_W-1:0] w_depth, w_base, w_pos;
    logic [DEPTH_W:0]   w_adv;

    // Step a position; the top bit flags a return to zero.
    function automatic logic [DEPTH_W:0] advance(input logic [DEPTH_W-1:0] pos,
                                                 input logic [DEPTH_W-1:0] depth);
        logic [DEPTH_W:0] nxt;
        nxt = {1'b0, pos} + 1'b1;
        if (nxt >= {1'b0, depth}) begin
            return {1'b1, {DEPTH_W{1'b0}}};
        end
        return {1'b0, nxt[DEPTH_W-1:0]};
    endfunction

    // Reduce base plus position modulo the store size by reciprocal multiplication.
    function automatic logic [AW-1:0] slot_mod(input logic [DEPTH_W:0] sum);
        logic [27:0] prod;
        logic [17:0] quo;
        logic [17:0] rem;
        prod = 28'(sum) * 28'(RECIP_MUL);
        quo  = 18'(prod >> RECIP_SHIFT);
        rem  = 18'(sum) - quo * 18'(TOTAL_SLOTS);
        return rem[AW-1:0];
    endfunction

    always_comb begin
        for (int q = 0; q < 2; q++) begin
            w_empty[q] = (r_rp[q] == r_wp[q]) && !r_wf[q];
            w_full[q]  = (r_rp[q] == r_wp[q]) &&  r_wf[q];
        end
    end

    assign i_in.ready = !i_fifo_full;
    assign w_acc      = i_in.valid && !i_fifo_full;
    assign w_deq      = (i_in.operation == OP_DEQ);
    // Strict priority: class 0 wins whenever it holds a packet.
    assign w_sel      = w_deq ? w_empty[0] : i_in.queue_class;
    assign w_depth    = w_sel ? r_depth1 : r_depth0;
    assign w_base     = w_sel ? r_depth0 : '0;
    assign w_pos      = w_deq ? r_rp[w_sel] : r_wp[w_sel];
    assign w_adv      = advance(w_pos, w_depth);

    always_comb begin
        o_ctl        = '0;
        o_ctl.status = ST_OK;
        if (w_deq) begin
            if (w_empty[0] && w_empty[1]) begin
                o_ctl.status = ST_EMPTY;
            end else begin
                o_ctl.rd  = 1'b1;
                o_ctl.cls = w_sel;
            end
        end else begin
            if (w_full[w_sel]) begin
                o_ctl.status = ST_FULL;
            end else begin
                o_ctl.wr = 1'b1;
            end
        end
    end

    assign o_push = w_acc;
    assign o_addr = slot_mod({1'b0, w_base} + {1'b0, w_pos});
    assign o_size = i_in.packet_size;
    assign o_data = i_in.packet_data;

    always_comb begin
        n_rp = r_rp;
        n_wp = r_wp;
        n_wf = r_wf;
        if (w_acc && o_ctl.wr) begin
            n_wp[w_sel] = w_adv[DEPTH_W-1:0];
            if (w_adv[DEPTH_W]) begin
                n_wf[w_sel] = 1'b1;
            end
        end
        if (w_acc && o_ctl.rd) begin
            n_rp[w_sel] = w_adv[DEPTH_W-1:0];
            if (w_adv[DEPTH_W]) begin
                n_wf[w_sel] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp     <= '{default: '0};
            r_wp     <= '{default: '0};
            r_wf     <= '0;
            r_depth0 <= CLASS0_DEPTH_RST;
            r_depth1 <= CLASS1_DEPTH_RST;
        end else begin
            r_rp <= n_rp;
            r_wp <= n_wp;
            r_wf <= n_wf;
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_CLASS0_DEPTH: r_depth0 <= i_cfg_data;
                    CFG_CLASS1_DEPTH: r_depth1 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> src/spcq_cmd_fifo.sv
// Command queue: short register FIFO between the front and back ends.
`default_nettype none
`include "strict_priority_class_queues_top_macros.svh"
module spcq_cmd_fifo
    import spcq_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = CMD_FIFO_DEPTH,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire  [W-1:0] i_data,
    output logic         o_full,
    output logic         o_vld,
    output logic [W-1:0] o_data,
    input  wire          i_pop
);
    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full = (r_count == CW'(DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `SPCQ_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(DEPTH), "fifo count overflow")
    `SPCQ_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, (i_pop && !i_push), (r_count == $past(r_count) - 1'b1), "fifo pop did not drain")
endmodule
`default_nettype wire

>>> src/spcq_back.sv
// Back end: shared slot store access and registered result stage.
`default_nettype none
`include "strict_priority_class_queues_top_macros.svh"
module spcq_back
    import spcq_pkg::*;
#(
    parameter int TOTAL_SLOTS = TOTAL_SLOTS_DEF,
    parameter int DATA_BITS   = DATA_BITS_DEF,
    localparam int AW         = $clog2(TOTAL_SLOTS)
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cmd_vld,
    output logic                 o_pop,
    input  wire t_cmd_ctl        i_ctl,
    input  wire  [AW-1:0]        i_addr,
    input  wire  [SIZE_W-1:0]    i_size,
    input  wire  [DATA_BITS-1:0] i_data,
    spcq_out_if.source           o_out
);
    logic [SIZE_W+DATA_BITS-1:0] r_mem [TOTAL_SLOTS];
    logic [SIZE_W+DATA_BITS-1:0] r_rd;
    logic                        r_s1_vld;
    t_cmd_ctl                    r_s1;
    logic                        r_o_vld;
    logic [1:0]                  r_o_status;
    logic                        r_o_class;
    logic [SIZE_W-1:0]           r_o_size;
    logic [DATA_BITS-1:0]        r_o_data;
    logic                        w_out_free, w_s1_adv;

    assign w_out_free = !r_o_vld || o_out.ready;
    assign w_s1_adv   = r_s1_vld && w_out_free;
    assign o_pop      = i_cmd_vld && (!r_s1_vld || w_s1_adv);

    // Commands reach the store in order, so a read always sees earlier writes.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_ctl.wr) begin
            r_mem[i_addr] <= {i_size, i_data};
        end
        if (o_pop && i_ctl.rd) begin
            r_rd <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_adv) begin
                r_o_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_ctl;
        end
        if (w_s1_adv) begin
            r_o_status <= r_s1.status;
            r_o_class  <= r_s1.rd ? r_s1.cls : 1'b0;
            r_o_size   <= r_s1.rd ? r_rd[SIZE_W+DATA_BITS-1:DATA_BITS] : '0;
            r_o_data   <= r_s1.rd ? r_rd[DATA_BITS-1:0] : '0;
        end
    end

    assign o_out.valid     = r_o_vld;
    assign o_out.status    = r_o_status;
    assign o_out.out_class = r_o_class;
    assign o_out.out_size  = r_o_size;
    assign o_out.out_data  = r_o_data;

    `SPCQ_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, (r_s1_vld && !w_s1_adv), r_s1_vld, "stage lost a stalled command")
    `SPCQ_ASSERT_NEXT(a_read_tracked, i_clk, i_rst_n, (o_pop && i_ctl.rd), (r_s1_vld && r_s1.rd), "read command not staged")
endmodule
`default_nettype wire

>>> src/strict_priority_class_queues_top.sv
// Top level: two strict priority packet rings sharing one slot store.
// Path: command FIFO, store read and result register; throughput is one
// command per cycle unless the command FIFO is full. The front end updates
// ring positions in the transfer cycle, the slot store one access per cycle.
// Reset (synchronous, active low) empties both rings, sets both depths to 16;
// the slot store is not cleared and no command is held off after reset.
`default_nettype none
module strict_priority_class_queues_top
    import spcq_pkg::*;
#(
    parameter int TOTAL_SLOTS = TOTAL_SLOTS_DEF,
    parameter int DATA_BITS   = DATA_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_index,
    input  wire  [DEPTH_W-1:0] i_cfg_data,
    spcq_in_if.sink            i_in,
    spcq_out_if.source         o_out
);
    localparam int AW = $clog2(TOTAL_SLOTS);
    localparam int FW = CMD_CTL_W + AW + SIZE_W + DATA_BITS;

    // Command handed from front to back: control, slot address and payload.
    logic                 w_push, w_pop, w_full, w_vld;
    t_cmd_ctl             w_f_ctl, w_b_ctl;
    logic [AW-1:0]        w_f_addr, w_b_addr;
    logic [SIZE_W-1:0]    w_f_size, w_b_size;
    logic [DATA_BITS-1:0] w_f_data, w_b_data;
    logic [FW-1:0]        w_q_in, w_q_out;

    // Classify each transfer and advance ring positions right away, so
    // the next command sees up-to-date full and empty state.
    spcq_front #(
        .TOTAL_SLOTS (TOTAL_SLOTS),
        .DATA_BITS   (DATA_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_fifo_full (w_full),
        .o_push      (w_push),
        .o_ctl       (w_f_ctl),
        .o_addr      (w_f_addr),
        .o_size      (w_f_size),
        .o_data      (w_f_data)
    );

    assign w_q_in = {w_f_ctl, w_f_addr, w_f_size, w_f_data};
    assign {w_b_ctl, w_b_addr, w_b_size, w_b_data} = w_q_out;

    // Decouple the two ends; the front stalls only when this fills.
    spcq_cmd_fifo #(
        .W     (FW),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .o_vld   (w_vld),
        .o_data  (w_q_out),
        .i_pop   (w_pop)
    );

    // Perform the store access and hold the result until transfer.
    spcq_back #(
        .TOTAL_SLOTS (TOTAL_SLOTS),
        .DATA_BITS   (DATA_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_vld),
        .o_pop     (w_pop),
        .i_ctl     (w_b_ctl),
        .i_addr    (w_b_addr),
        .i_size    (w_b_size),
        .i_data    (w_b_data),
        .o_out     (o_out)
    );
endmodule
`default_nettype wire
